// ===== rtl/kat_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key action timer table package
// Shared types, codes and the payload classifier for the timer table block.
// ----------------------------------------------------------------------------
package kat_pkg;

    // Input item kinds
    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Key routes
    localparam logic [1:0] ROUTE_ANALOG    = 2'd0;
    localparam logic [1:0] ROUTE_MOMENTARY = 2'd1;
    localparam logic [1:0] ROUTE_TOGGLE    = 2'd2;
    localparam logic [1:0] ROUTE_SPECIAL   = 2'd3;

    // Scheduled actions
    localparam logic [1:0] ACT_SET    = 2'd0;
    localparam logic [1:0] ACT_UNSET  = 2'd1;
    localparam logic [1:0] ACT_TOGGLE = 2'd2;

    // Event targets
    localparam logic [2:0] TGT_KEYBOARD = 3'd0;
    localparam logic [2:0] TGT_LAYER    = 3'd1;
    localparam logic [2:0] TGT_JOYSTICK = 3'd2;
    localparam logic [2:0] TGT_MOUSE    = 3'd3;
    localparam logic [2:0] TGT_LOCK     = 3'd4;
    localparam logic [2:0] TGT_NONE     = 3'd5;

    // Configuration register indexes
    localparam logic [7:0] CFG_PRESS_THR   = 8'd0;
    localparam logic [7:0] CFG_RELEASE_THR = 8'd1;

    localparam logic [7:0] PRESS_THR_RST   = 8'd128;
    localparam logic [7:0] RELEASE_THR_RST = 8'd64;

    // Payload ranges
    localparam logic [7:0] KBD_LO_END  = 8'hA4;
    localparam logic [7:0] KBD_MOD_LO  = 8'hE0;
    localparam logic [7:0] KBD_MOD_HI  = 8'hE7;
    localparam logic [7:0] LAYER_LO    = 8'hD0;
    localparam logic [7:0] LAYER_HI    = 8'hDF;
    localparam logic [7:0] JOY_LO      = 8'hB0;
    localparam logic [7:0] JOY_HI      = 8'hCF;
    localparam logic [7:0] MOUSE_LO    = 8'hA5;
    localparam logic [7:0] MOUSE_HI    = 8'hAA;
    localparam logic [7:0] LOCK_CODE   = 8'hFF;

    typedef enum logic [2:0] {
        S_IDLE,
        S_KEY,
        S_SCAN,
        S_PLACE,
        S_TICK,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic [7:0]  payload;
        logic [1:0]  action;
        logic [15:0] delay;
    } t_entry;

    typedef struct packed {
        logic load;
        logic walk_start;
        logic key_eval;
        logic walk_run;
        logic place;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic sched;
        logic walk_done;
        logic pend_vld;
    } t_stat;

    typedef struct packed {
        logic [2:0] target;
        logic [7:0] index;
    } t_class;

    function automatic t_class classify(input logic [7:0] p);
        t_class c;
        c.target = TGT_NONE;
        c.index  = 8'd0;
        if (p <= KBD_LO_END || (p >= KBD_MOD_LO && p <= KBD_MOD_HI)) begin
            c.target = TGT_KEYBOARD;
            c.index  = p;
        end else if (p >= LAYER_LO && p <= LAYER_HI) begin
            c.target = TGT_LAYER;
            c.index  = p - LAYER_LO;
        end else if (p >= JOY_LO && p <= JOY_HI) begin
            c.target = TGT_JOYSTICK;
            c.index  = p - JOY_LO;
        end else if (p >= MOUSE_LO && p <= MOUSE_HI) begin
            c.target = TGT_MOUSE;
            c.index  = p - MOUSE_LO;
        end else if (p == LOCK_CODE) begin
            c.target = TGT_LOCK;
        end
        return c;
    endfunction

endpackage

// ===== rtl/kat_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key action timer table controller
// Sequences key evaluation, slot scan, placement, tick walk and final flush.
// ----------------------------------------------------------------------------
module kat_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_operation,
    input  kat_pkg::t_stat  i_stat,
    output kat_pkg::t_cmd   o_cmd
);
    import kat_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_operation == OP_TICK) ? S_TICK : S_KEY;
                end
            end
            S_KEY: begin
                n_state = i_stat.sched ? S_SCAN : S_IDLE;
            end
            S_SCAN: begin
                if (i_stat.walk_done) begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                n_state = S_IDLE;
            end
            S_TICK: begin
                if (i_stat.walk_done) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!i_stat.pend_vld) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready       = 1'b1;
                o_cmd.load       = i_in_valid;
                o_cmd.walk_start = i_in_valid;
            end
            S_KEY: begin
                o_cmd.key_eval = 1'b1;
            end
            S_SCAN, S_TICK: begin
                o_cmd.walk_run = 1'b1;
            end
            S_PLACE: begin
                o_cmd.place = 1'b1;
            end
            S_FLUSH: begin
                o_cmd.flush = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/kat_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key action timer table datapath
// Thresholds, pressed flags, slot memory, slot walk and result register.
// ----------------------------------------------------------------------------
module kat_dp #(
    parameter int KEY_COUNT  = 16,
    parameter int SLOT_COUNT = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  kat_pkg::t_cmd   i_cmd,
    output kat_pkg::t_stat  o_stat,
    input  logic            i_operation,
    input  logic [3:0]      i_key_index,
    input  logic [7:0]      i_key_depth,
    input  logic [1:0]      i_key_route,
    input  logic [7:0]      i_key_payload,
    input  logic [15:0]     i_action_delay,
    input  logic [15:0]     i_elapsed_ms,
    input  logic            i_cfg_valid,
    input  logic [7:0]      i_cfg_index,
    input  logic [7:0]      i_cfg_data,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    output logic [7:0]      o_event_payload,
    output logic [1:0]      o_event_action,
    output logic [2:0]      o_event_target,
    output logic [7:0]      o_target_index,
    output logic            o_last_of_run
);
    import kat_pkg::*;

    localparam int KEY_SLOTS = (KEY_COUNT < 16) ? KEY_COUNT : 16;
    localparam int KIDX_W    = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    localparam int SIDX_W    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W     = $clog2(SLOT_COUNT + 1);

    // Configuration
    logic [7:0] r_press_thr, r_release_thr;

    // Captured item
    logic        r_op;
    logic [3:0]  r_key;
    logic [7:0]  r_depth;
    logic [1:0]  r_route;
    logic [7:0]  r_payload;
    logic [15:0] r_delay;
    logic [15:0] r_elapsed;

    logic [KEY_SLOTS-1:0] r_pressed;
    logic [1:0]           r_sched_act;

    // Slot store
    t_entry                r_mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_valid;

    // Walk
    logic [CNT_W-1:0]  r_rd_idx;
    logic              r_q_vld;
    logic [SIDX_W-1:0] r_q_idx;
    t_entry            r_q;

    // Scan results
    logic              r_free_found;
    logic [SIDX_W-1:0] r_free_idx;
    logic [15:0]       r_worst;
    logic [SIDX_W-1:0] r_victim;

    // Pending result and output register
    logic   r_pend_vld;
    t_entry r_pend;
    logic   r_out_vld;
    t_entry r_out;
    logic   r_out_last;

    logic              key_ok, cur_pressed, down, up, sched;
    logic [1:0]        act;
    logic              rd_more, advance, is_tick, q_busy, due, stall, out_free;
    logic              tick_due, tick_keep, scan_proc, push_walk, push_flush, push;
    logic              place_we, mem_we;
    logic [SIDX_W-1:0] mem_waddr;
    t_entry            mem_wdata;
    t_class            cls;

    // Key hysteresis
    always_comb begin
        key_ok      = (r_payload != 8'd0) && ({5'd0, r_key} < 9'(KEY_COUNT));
        cur_pressed = r_pressed[r_key[KIDX_W-1:0]];
        down        = key_ok && !cur_pressed && (r_depth > r_press_thr);
        up          = key_ok && cur_pressed && (r_depth < r_release_thr);
        sched       = ((r_route == ROUTE_MOMENTARY) && (down || up)) ||
                      ((r_route == ROUTE_TOGGLE) && down);
        if (down) begin
            act = (r_route == ROUTE_TOGGLE) ? ACT_TOGGLE : ACT_SET;
        end else begin
            act = ACT_UNSET;
        end
    end

    // Walk control
    always_comb begin
        out_free   = !r_out_vld || i_out_ready;
        rd_more    = (r_rd_idx != CNT_W'(SLOT_COUNT));
        is_tick    = (r_op == OP_TICK);
        q_busy     = r_valid[r_q_idx];
        due        = q_busy && (r_q.delay <= r_elapsed);
        stall      = r_q_vld && is_tick && due && r_pend_vld && !out_free;
        advance    = i_cmd.walk_run && !stall;
        tick_due   = advance && r_q_vld && is_tick && due;
        tick_keep  = advance && r_q_vld && is_tick && q_busy && !due;
        scan_proc  = advance && r_q_vld && !is_tick;
        push_walk  = tick_due && r_pend_vld;
        push_flush = i_cmd.flush && r_pend_vld && out_free;
        push       = push_walk || push_flush;
        place_we   = i_cmd.place && (r_free_found || (r_delay < r_worst));
    end

    // Memory write port: placement or wait update
    always_comb begin
        mem_we    = place_we || tick_keep;
        mem_waddr = r_q_idx;
        mem_wdata = '{payload: r_q.payload, action: r_q.action,
                      delay: r_q.delay - r_elapsed};
        if (place_we) begin
            mem_waddr = r_free_found ? r_free_idx : r_victim;
            mem_wdata = '{payload: r_payload, action: r_sched_act, delay: r_delay};
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (advance && rd_more) begin
            r_q <= r_mem[r_rd_idx[SIDX_W-1:0]];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_thr   <= PRESS_THR_RST;
            r_release_thr <= RELEASE_THR_RST;
            r_pressed     <= '0;
            r_valid       <= '0;
            r_rd_idx      <= '0;
            r_q_vld       <= 1'b0;
            r_free_found  <= 1'b0;
            r_pend_vld    <= 1'b0;
            r_out_vld     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_PRESS_THR:   r_press_thr   <= i_cfg_data;
                    CFG_RELEASE_THR: r_release_thr <= i_cfg_data;
                    default: ;
                endcase
            end

            if (i_cmd.key_eval) begin
                if (down) begin
                    r_pressed[r_key[KIDX_W-1:0]] <= 1'b1;
                end else if (up) begin
                    r_pressed[r_key[KIDX_W-1:0]] <= 1'b0;
                end
            end

            if (place_we) begin
                r_valid[mem_waddr] <= 1'b1;
            end
            if (tick_due) begin
                r_valid[r_q_idx] <= 1'b0;
            end

            if (i_cmd.walk_start) begin
                r_rd_idx     <= '0;
                r_q_vld      <= 1'b0;
                r_free_found <= 1'b0;
            end else if (advance) begin
                r_q_vld <= rd_more;
                if (rd_more) begin
                    r_rd_idx <= r_rd_idx + CNT_W'(1);
                end
                if (scan_proc && !r_free_found && !q_busy) begin
                    r_free_found <= 1'b1;
                end
            end

            if (tick_due) begin
                r_pend_vld <= 1'b1;
            end else if (push_flush) begin
                r_pend_vld <= 1'b0;
            end

            if (push) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_operation;
            r_key     <= i_key_index;
            r_depth   <= i_key_depth;
            r_route   <= i_key_route;
            r_payload <= i_key_payload;
            r_delay   <= i_action_delay;
            r_elapsed <= i_elapsed_ms;
        end
        if (i_cmd.key_eval) begin
            r_sched_act <= act;
        end
        if (i_cmd.walk_start) begin
            r_worst  <= '0;
            r_victim <= '0;
        end else if (scan_proc) begin
            if (!r_free_found && !q_busy) begin
                r_free_idx <= r_q_idx;
            end else if (q_busy && (r_q.delay > r_worst)) begin
                r_worst  <= r_q.delay;
                r_victim <= r_q_idx;
            end
        end
        if (advance && rd_more) begin
            r_q_idx <= r_rd_idx[SIDX_W-1:0];
        end
        if (tick_due) begin
            r_pend <= r_q;
        end
        if (push) begin
            r_out      <= r_pend;
            r_out_last <= push_flush;
        end
    end

    always_comb begin
        cls                = classify(r_out.payload);
        o_out_valid        = r_out_vld;
        o_event_payload    = r_out.payload;
        o_event_action     = r_out.action;
        o_event_target     = cls.target;
        o_target_index     = cls.index;
        o_last_of_run      = r_out_last;
        o_stat.sched       = sched;
        o_stat.walk_done   = !rd_more && !r_q_vld;
        o_stat.pend_vld    = r_pend_vld;
    end

endmodule

// ===== rtl/key_action_timer_table.sv =====
`timescale 1ns / 1ps
// A key sample without an edge is evaluated and returns to idle; one that
// schedules an action also scans every slot, then tries to place it. A tick walks
// every slot and then flushes; a held result port can stall the walk or the flush.
// Items are taken only in idle; the walk reads one slot per cycle unless stalled.
// Reset (synchronous, active low) releases all keys, empties all slots and
// loads thresholds 128 (press) and 64 (release).
// ----------------------------------------------------------------------------
// Key action timer table
// Key hysteresis feeding a delayed action table that fires on time ticks.
// ----------------------------------------------------------------------------
module key_action_timer_table #(
    parameter int KEY_COUNT  = 16,
    parameter int SLOT_COUNT = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Item channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_operation,
    input  logic [3:0]  i_key_index,
    input  logic [7:0]  i_key_depth,
    input  logic [1:0]  i_key_route,
    input  logic [7:0]  i_key_payload,
    input  logic [15:0] i_action_delay,
    input  logic [15:0] i_elapsed_ms,
    // Configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // Result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_event_payload,
    output logic [1:0]  o_event_action,
    output logic [2:0]  o_event_target,
    output logic [7:0]  o_target_index,
    output logic        o_last_of_run
);
    import kat_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Register writes need no wait, so the port never holds a transaction.
    assign o_cfg_ready = 1'b1;

    // Controller: accept an item in idle, then evaluate a key sample and, if it
    // schedules an action, scan and place; or walk and flush for a tick.
    kat_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Datapath: hold thresholds and pressed flags, walk the slot memory, and
    // keep one due event pending so the last one of a tick can be flagged.
    kat_dp #(
        .KEY_COUNT  (KEY_COUNT),
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_operation     (i_operation),
        .i_key_index     (i_key_index),
        .i_key_depth     (i_key_depth),
        .i_key_route     (i_key_route),
        .i_key_payload   (i_key_payload),
        .i_action_delay  (i_action_delay),
        .i_elapsed_ms    (i_elapsed_ms),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_event_payload (o_event_payload),
        .o_event_action  (o_event_action),
        .o_event_target  (o_event_target),
        .o_target_index  (o_target_index),
        .o_last_of_run   (o_last_of_run)
    );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key action timer table testbench
// Feeds key samples and time ticks through the item channel, predicts every
// due event with a cycle-free model of the key flags and the slot table, and
// checks each event field by field while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    import kat_pkg::*;

    localparam int KEY_N         = 16;
    localparam int SLOT_N        = 16;
    // Slowest legal tick walks all SLOT_N slots plus up to 16 stalled events;
    // the long receiver hold is the longest quiet stretch a good run can see.
    localparam int QUIET_LIMIT   = 4000;
    localparam int RX_HOLD       = 300;
    // A scheduling key sample walks every slot and yields no event,
    // so give it twice the walk before touching the registers.
    localparam int SETTLE_CYCLES = 2 * SLOT_N;

    // Register indexes past the end of the list; writes there are ignored.
    localparam logic [7:0] CFG_SPARE = CFG_RELEASE_THR + 8'd1;
    localparam logic [7:0] CFG_TOP   = 8'hFF;

    // Payloads on and around the range boundaries of the classifier.
    localparam int         EDGE_N     = 15;
    localparam logic [EDGE_N*8-1:0] EDGE_CODES = {
        8'h01, 8'hA4, 8'hA5, 8'hAA, 8'hAB, 8'hAF, 8'hB0, 8'hCF,
        8'hD0, 8'hDF, 8'hE0, 8'hE7, 8'hE8, 8'hFE, 8'hFF
    };

    typedef enum int {
        MODE_SPREAD,  // mixed delays and ticks, table mostly sparse
        MODE_CROWD,   // long delays, rare short ticks: table fills, victims swap
        MODE_BURST    // zero delays, frequent ticks: event bursts
    } t_mode;

    typedef struct packed {
        logic        op;
        logic [3:0]  key;
        logic [7:0]  depth;
        logic [1:0]  route;
        logic [7:0]  payload;
        logic [15:0] delay;
        logic [15:0] elapsed;
    } t_item;

    typedef struct packed {
        logic [7:0] payload;
        logic [1:0] action;
        logic [2:0] target;
        logic [7:0] index;
        logic       last;
    } t_event;

    // One stimulus row; a typed row carries its own event (or none) instead
    // of taking the predicted ones.
    typedef struct packed {
        t_item  it;
        logic   typed;
        logic   has_ev;
        t_event ev;
    } t_row;

    // ------------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------------
    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic        o_in_ready;
    logic        i_operation    = OP_KEY;
    logic [3:0]  i_key_index    = 4'd0;
    logic [7:0]  i_key_depth    = 8'd0;
    logic [1:0]  i_key_route    = ROUTE_ANALOG;
    logic [7:0]  i_key_payload  = 8'd0;
    logic [15:0] i_action_delay = 16'd0;
    logic [15:0] i_elapsed_ms   = 16'd0;
    logic        i_cfg_valid    = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index    = 8'd0;
    logic [7:0]  i_cfg_data     = 8'd0;
    logic        o_out_valid;
    logic        i_out_ready    = 1'b0;
    logic [7:0]  o_event_payload;
    logic [1:0]  o_event_action;
    logic [2:0]  o_event_target;
    logic [7:0]  o_target_index;
    logic        o_last_of_run;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    key_action_timer_table #(
        .KEY_COUNT  (KEY_N),
        .SLOT_COUNT (SLOT_N)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_operation     (i_operation),
        .i_key_index     (i_key_index),
        .i_key_depth     (i_key_depth),
        .i_key_route     (i_key_route),
        .i_key_payload   (i_key_payload),
        .i_action_delay  (i_action_delay),
        .i_elapsed_ms    (i_elapsed_ms),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_event_payload (o_event_payload),
        .o_event_action  (o_event_action),
        .o_event_target  (o_event_target),
        .o_target_index  (o_target_index),
        .o_last_of_run   (o_last_of_run)
    );

    // ------------------------------------------------------------------------
    // Predictor state: key flags, slot table, thresholds
    // ------------------------------------------------------------------------
    logic        key_down  [KEY_N];
    logic [7:0]  slot_pay  [SLOT_N];   // zero marks a free slot
    logic [1:0]  slot_act  [SLOT_N];
    logic [15:0] slot_wait [SLOT_N];
    logic [7:0]  thr_press   = PRESS_THR_RST;
    logic [7:0]  thr_release = RELEASE_THR_RST;

    t_event      fired_q[$];    // events of the item just predicted
    t_event      pending_q[$];  // events still owed by the block, oldest first

    int          fail_count   = 0;
    int          quiet_cycles = 0;
    int          hold_asked   = 0;
    int          hold_served  = 0;
    int          hold_left    = 0;
    int          rx_gap_left  = 0;
    logic        rx_idle_en   = 1'b1;
    logic        tx_idle_en   = 1'b1;

    // Take the first free slot; with the table full, evict the lowest slot
    // holding the longest wait, but only for a strictly shorter delay.
    function automatic void book_slot(input logic [7:0] payload, input logic [1:0] act,
                                      input logic [15:0] delay);
        logic [15:0] worst;
        int          victim;
        worst  = 16'd0;
        victim = 0;
        for (int s = 0; s < SLOT_N; s++) begin
            if (slot_pay[s] == 8'd0) begin
                slot_pay[s]  = payload;
                slot_act[s]  = act;
                slot_wait[s] = delay;
                return;
            end
            if (slot_wait[s] > worst) begin
                worst  = slot_wait[s];
                victim = s;
            end
        end
        if (delay < worst) begin
            slot_pay[victim]  = payload;
            slot_act[victim]  = act;
            slot_wait[victim] = delay;
        end
    endfunction

    // Advance the model by one item and leave its due events in fired_q.
    function automatic void predict_item(input t_item it);
        logic   went_down;
        logic   went_up;
        t_event ev;
        fired_q.delete();
        went_down = 1'b0;
        went_up   = 1'b0;
        if (it.op == OP_KEY) begin
            // A sample without an action code leaves even the key flag alone.
            if (it.payload == 8'd0)
                return;
            if (key_down[it.key]) begin
                if (it.depth < thr_release) begin
                    key_down[it.key] = 1'b0;
                    went_up = 1'b1;
                end
            end else if (it.depth > thr_press) begin
                key_down[it.key] = 1'b1;
                went_down = 1'b1;
            end
            if (it.route == ROUTE_MOMENTARY) begin
                if (went_down)
                    book_slot(it.payload, ACT_SET, it.delay);
                else if (went_up)
                    book_slot(it.payload, ACT_UNSET, it.delay);
            end else if (it.route == ROUTE_TOGGLE && went_down) begin
                book_slot(it.payload, ACT_TOGGLE, it.delay);
            end
            return;
        end
        for (int s = 0; s < SLOT_N; s++) begin
            if (slot_pay[s] == 8'd0)
                continue;
            if (slot_wait[s] <= it.elapsed) begin
                ev.payload = slot_pay[s];
                ev.action  = slot_act[s];
                ev.last    = 1'b0;
                ev.target  = TGT_NONE;
                ev.index   = 8'd0;
                if (ev.payload == LOCK_CODE) begin
                    ev.target = TGT_LOCK;
                end else if (ev.payload >= MOUSE_LO && ev.payload <= MOUSE_HI) begin
                    ev.target = TGT_MOUSE;
                    ev.index  = ev.payload - MOUSE_LO;
                end else if (ev.payload >= JOY_LO && ev.payload <= JOY_HI) begin
                    ev.target = TGT_JOYSTICK;
                    ev.index  = ev.payload - JOY_LO;
                end else if (ev.payload >= LAYER_LO && ev.payload <= LAYER_HI) begin
                    ev.target = TGT_LAYER;
                    ev.index  = ev.payload - LAYER_LO;
                end else if (ev.payload <= KBD_LO_END ||
                             (ev.payload >= KBD_MOD_LO && ev.payload <= KBD_MOD_HI)) begin
                    ev.target = TGT_KEYBOARD;
                    ev.index  = ev.payload;
                end
                fired_q.push_back(ev);
                slot_pay[s] = 8'd0;
            end else begin
                slot_wait[s] = slot_wait[s] - it.elapsed;
            end
        end
        // Flag the final event of the tick.
        if (fired_q.size() > 0) begin
            ev = fired_q.pop_back();
            ev.last = 1'b1;
            fired_q.push_back(ev);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus rows
    // ------------------------------------------------------------------------
    function automatic t_row key_row(input logic [3:0] key, input logic [7:0] depth,
                                     input logic [1:0] route, input logic [7:0] payload,
                                     input logic [15:0] delay);
        t_row r;
        r            = '0;
        r.it.op      = OP_KEY;
        r.it.key     = key;
        r.it.depth   = depth;
        r.it.route   = route;
        r.it.payload = payload;
        r.it.delay   = delay;
        return r;
    endfunction

    // typed with has_ev low means the tick must return nothing.
    function automatic t_row tick_row(input logic [15:0] elapsed, input logic typed,
                                      input logic has_ev, input logic [7:0] payload,
                                      input logic [1:0] act, input logic [2:0] tgt,
                                      input logic [7:0] idx);
        t_row r;
        r            = '0;
        r.it.op      = OP_TICK;
        r.it.elapsed = elapsed;
        r.typed      = typed;
        r.has_ev     = has_ev;
        r.ev         = {payload, act, tgt, idx, 1'b1};
        return r;
    endfunction

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    // Random ticks and mostly well-formed key strokes that cross the thresholds,
    // with noise in the fields that the item kind does not use.
    function automatic t_row random_row(input t_mode mode);
        t_row r;
        int   roll;
        int   tick_pct;
        int   k;
        r.typed  = 1'b0;
        r.has_ev = 1'b0;
        r.ev     = '0;
        r.it.key     = 4'($urandom_range(0, KEY_N - 1));
        r.it.depth   = 8'($urandom_range(0, 255));
        r.it.route   = 2'($urandom_range(0, 3));
        r.it.payload = 8'($urandom_range(0, 255));
        r.it.delay   = 16'($urandom_range(0, 65535));
        r.it.elapsed = 16'($urandom_range(0, 65535));
        tick_pct = (mode == MODE_CROWD) ? 10 : (mode == MODE_BURST) ? 35 : 30;
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < tick_pct) begin
            r.it.op = OP_TICK;
            if (mode == MODE_BURST)
                r.it.elapsed = 16'($urandom_range(0, 5));
            else if (roll < 5)
                r.it.elapsed = 16'hFFFF;
            else if (roll < 12)
                r.it.elapsed = 16'($urandom_range(0, 65535));
            else if (mode == MODE_CROWD)
                r.it.elapsed = 16'((roll < 80) ? $urandom_range(0, 3) : $urandom_range(0, 500));
            else
                r.it.elapsed = 16'((roll < 22) ? 0 : $urandom_range(0, 60));
            return r;
        end
        r.it.op = OP_KEY;
        r.it.route = (roll < 40) ? ROUTE_MOMENTARY : (roll < 70) ? ROUTE_TOGGLE :
                     (roll < 85) ? ROUTE_ANALOG : ROUTE_SPECIAL;
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
            r.it.payload = 8'd0;
        end else if (roll < 45) begin
            k = $urandom_range(0, EDGE_N - 1);
            r.it.payload = EDGE_CODES[8*k +: 8];
        end else begin
            r.it.payload = 8'($urandom_range(1, 255));
        end
        // Push the depth across the threshold that matters for this key.
        roll = $urandom_range(0, 9);
        if (key_down[r.it.key] && thr_release != 8'd0 && roll < 7)
            r.it.depth = 8'($urandom_range(0, thr_release - 1));
        else if (!key_down[r.it.key] && thr_press != 8'hFF && roll < 7)
            r.it.depth = 8'($urandom_range(thr_press + 1, 255));
        roll = $urandom_range(0, 99);
        case (mode)
            MODE_CROWD: begin
                if (roll < 10)
                    r.it.delay = 16'hFFFF;
                else if (roll < 15)
                    r.it.delay = 16'($urandom_range(0, 5));
                else
                    r.it.delay = 16'($urandom_range(200, 65535));
            end
            MODE_BURST: begin
                r.it.delay = 16'((roll < 60) ? 0 : $urandom_range(0, 10));
            end
            default: begin
                if (roll < 10)
                    r.it.delay = 16'd0;
                else if (roll < 15)
                    r.it.delay = 16'hFFFF;
                else if (roll >= 25)
                    r.it.delay = 16'($urandom_range(1, 80));
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Item and register channels
    // ------------------------------------------------------------------------
    // Raise valid, hold the payload until the transaction, then predict.
    // Valid is left high; the caller drops it only when it idles.
    task automatic offer_item(input t_row r);
        i_in_valid     <= 1'b1;
        i_operation    <= r.it.op;
        i_key_index    <= r.it.key;
        i_key_depth    <= r.it.depth;
        i_key_route    <= r.it.route;
        i_key_payload  <= r.it.payload;
        i_action_delay <= r.it.delay;
        i_elapsed_ms   <= r.it.elapsed;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        predict_item(r.it);
        if (r.typed) begin
            if (r.has_ev)
                pending_q.push_back(r.ev);
        end else begin
            foreach (fired_q[k])
                pending_q.push_back(fired_q[k]);
        end
    endtask

    task automatic maybe_gap();
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat (gap_len())
                @(posedge i_clk);
        end
    endtask

    // Drop valid, wait for every owed event, then let a silent key sample
    // finish its walk.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        if (idx == CFG_PRESS_THR)
            thr_press = val;
        else if (idx == CFG_RELEASE_THR)
            thr_release = val;
    endtask

    // ------------------------------------------------------------------------
    // Event sink: check each transaction, then pick next cycle's ready
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : event_sink
        t_event want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_q.size() == 0) begin
                $error("event_payload: expected nothing, got %0h", o_event_payload);
                fail_count++;
            end else begin
                want = pending_q.pop_front();
                check_field("event_payload", want.payload, o_event_payload);
                check_field("event_action", 8'(want.action), 8'(o_event_action));
                check_field("event_target", 8'(want.target), 8'(o_event_target));
                check_field("target_index", want.index, o_target_index);
                check_field("last_of_run", 8'(want.last), 8'(o_last_of_run));
            end
        end
        // Long hold on request; otherwise, with idling enabled, short and occasional long gaps.
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (hold_served != hold_asked) begin
            hold_served++;
            hold_left = RX_HOLD - 1;
            i_out_ready <= 1'b0;
        end else if (!rx_idle_en) begin
            i_out_ready <= 1'b1;
        end else if (rx_gap_left > 0) begin
            rx_gap_left--;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            rx_gap_left = gap_len() - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Watchdog: end the run when no transaction moves on any channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_row  plan[$];
        t_mode mode;
        int    count;

        for (int k = 0; k < KEY_N; k++)
            key_down[k] = 1'b0;
        for (int s = 0; s < SLOT_N; s++) begin
            slot_pay[s]  = 8'd0;
            slot_act[s]  = ACT_SET;
            slot_wait[s] = 16'd0;
        end

        // Directed rows, reset thresholds 128 / 64.
        // Empty table: a tick returns nothing.
        plan.push_back(tick_row(16'd0, 1'b1, 1'b0, 8'd0, ACT_SET, TGT_NONE, 8'd0));
        // Press with zero delay fires on the next zero-length tick (lock code).
        plan.push_back(key_row(4'd0, 8'd255, ROUTE_MOMENTARY, LOCK_CODE, 16'd0));
        plan.push_back(tick_row(16'd0, 1'b1, 1'b1, LOCK_CODE, ACT_SET, TGT_LOCK, 8'd0));
        // Release schedules UNSET with the longest delay; the longest tick fires it.
        plan.push_back(key_row(4'd0, 8'd0, ROUTE_MOMENTARY, KBD_MOD_HI, 16'hFFFF));
        plan.push_back(tick_row(16'hFFFF, 1'b1, 1'b1, KBD_MOD_HI, ACT_UNSET, TGT_KEYBOARD,
                                KBD_MOD_HI));
        // Toggle press just over threshold; not due at zero, due at one.
        plan.push_back(key_row(4'd15, 8'd129, ROUTE_TOGGLE, LAYER_LO, 16'd1));
        plan.push_back(tick_row(16'd0, 1'b1, 1'b0, 8'd0, ACT_SET, TGT_NONE, 8'd0));
        plan.push_back(tick_row(16'd1, 1'b1, 1'b1, LAYER_LO, ACT_TOGGLE, TGT_LAYER, 8'd0));
        // Toggle release schedules nothing.
        plan.push_back(key_row(4'd15, 8'd0, ROUTE_TOGGLE, LAYER_LO, 16'd0));
        plan.push_back(tick_row(16'hFFFF, 1'b1, 1'b0, 8'd0, ACT_SET, TGT_NONE, 8'd0));
        // Depth equal to the press threshold is no edge.
        plan.push_back(key_row(4'd1, 8'd128, ROUTE_MOMENTARY, 8'h01, 16'd0));
        // Analog and special routes press the key but schedule nothing.
        plan.push_back(key_row(4'd2, 8'd255, ROUTE_ANALOG, MOUSE_LO, 16'd0));
        plan.push_back(key_row(4'd3, 8'd255, ROUTE_SPECIAL, JOY_LO, 16'd0));
        // No action code: ignored, key 4 stays released.
        plan.push_back(key_row(4'd4, 8'd255, ROUTE_MOMENTARY, 8'd0, 16'd0));
        plan.push_back(key_row(4'd4, 8'd255, ROUTE_MOMENTARY, JOY_HI, 16'd5));
        // Depth equal to the release threshold is no edge; one below releases.
        plan.push_back(key_row(4'd4, 8'd64, ROUTE_MOMENTARY, MOUSE_HI, 16'd3));
        plan.push_back(key_row(4'd4, 8'd63, ROUTE_MOMENTARY, MOUSE_HI, 16'd3));
        plan.push_back(key_row(4'd5, 8'd200, ROUTE_MOMENTARY, KBD_LO_END, 16'd2));
        plan.push_back(key_row(4'd6, 8'd200, ROUTE_TOGGLE, KBD_MOD_LO, 16'd2));
        // Payloads outside every range.
        plan.push_back(key_row(4'd7, 8'd200, ROUTE_MOMENTARY, 8'hF0, 16'd4));
        plan.push_back(key_row(4'd8, 8'd200, ROUTE_MOMENTARY, 8'hAB, 16'd4));
        // One tick drains the six booked slots in index order.
        plan.push_back(tick_row(16'hFFFF, 1'b0, 1'b0, 8'd0, ACT_SET, TGT_NONE, 8'd0));

        repeat (12)
            @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            offer_item(plan[i]);
            maybe_gap();
        end
        settle();

        // Random phases, each under its own thresholds.
        for (int ph = 0; ph < 6; ph++) begin
            tx_idle_en = 1'b1;
            rx_idle_en = 1'b1;
            count      = 80;
            case (ph)
                0: begin
                    // Lowest press, highest release: nearly every sample is an edge.
                    write_reg(CFG_PRESS_THR, 8'd0);
                    write_reg(CFG_RELEASE_THR, 8'd255);
                    mode = MODE_BURST;
                end
                1: begin
                    // No key can change state; ticks drain what is left.
                    write_reg(CFG_PRESS_THR, 8'd255);
                    write_reg(CFG_RELEASE_THR, 8'd0);
                    mode  = MODE_SPREAD;
                    count = 40;
                end
                2: begin
                    // Writes past the register list must change nothing.
                    write_reg(CFG_SPARE, 8'($urandom_range(0, 255)));
                    write_reg(CFG_TOP, 8'($urandom_range(0, 255)));
                    write_reg(CFG_PRESS_THR, 8'($urandom_range(0, 255)));
                    write_reg(CFG_RELEASE_THR, 8'($urandom_range(0, 255)));
                    mode       = MODE_CROWD;
                    count      = 90;
                    tx_idle_en = 1'b0;
                    rx_idle_en = 1'b0;
                end
                3: begin
                    write_reg(CFG_RELEASE_THR, 8'd100);
                    write_reg(CFG_PRESS_THR, 8'd200);
                    mode = MODE_SPREAD;
                end
                4: begin
                    write_reg(CFG_PRESS_THR, 8'($urandom_range(0, 255)));
                    write_reg(CFG_RELEASE_THR, 8'($urandom_range(0, 255)));
                    mode = MODE_CROWD;
                end
                default: begin
                    write_reg(CFG_PRESS_THR, PRESS_THR_RST);
                    write_reg(CFG_RELEASE_THR, RELEASE_THR_RST);
                    mode = MODE_SPREAD;
                end
            endcase
            i_cfg_valid <= 1'b0;

            for (int n = 0; n < count; n++) begin
                // Hold the sink off while bursts keep coming: the block backs up.
                if (ph == 0 && n == count / 2)
                    hold_asked++;
                // Pause the source until every owed event is out.
                if (ph == 3 && n == count / 2)
                    settle();
                offer_item(random_row(mode));
                maybe_gap();
            end
            settle();
        end

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
